// ===== src/ipcfd_pkg.sv =====
package ipcfd_pkg;

    localparam int LENGTH_WIDTH = 32;
    localparam int TAG_BITS     = 32;
    localparam int POS_BITS     = 34;
    localparam int NUM_TAGS     = 6;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_HELLO     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_READY     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_ACTIVATED = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_COMMAND   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_STOP      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_READY_V2  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LENGTH    = 3'd6;

    localparam logic [TAG_BITS-1:0] MAX_LENGTH_RESET = 32'd4096;

    localparam logic [POS_BITS-1:0] END_HELLO      = 34'd9;
    localparam logic [POS_BITS-1:0] END_READY      = 34'd4;
    localparam logic [POS_BITS-1:0] END_ACTIVATED  = 34'd16;
    localparam logic [POS_BITS-1:0] END_STOP       = 34'd12;
    localparam logic [POS_BITS-1:0] LEN_COMMAND    = 34'd8;
    localparam logic [POS_BITS-1:0] LEN_FIRST_V2   = 34'd25;
    localparam logic [POS_BITS-1:0] CMD_OVERHEAD   = 34'd9;
    localparam logic [POS_BITS-1:0] V2_SECOND_BASE = 34'd29;
    localparam logic [POS_BITS-1:0] V2_TRAILER     = 34'd8;

    typedef enum logic [2:0] {
        KIND_HELLO     = 3'd0,
        KIND_READY     = 3'd1,
        KIND_ACTIVATED = 3'd2,
        KIND_COMMAND   = 3'd3,
        KIND_STOP      = 3'd4,
        KIND_READY_V2  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [NUM_TAGS-1:0][TAG_BITS-1:0] tag;
        logic [TAG_BITS-1:0]               max_length;
    } cfg_t;

    typedef struct packed {
        logic  halted;
        logic  frame_invalid;
        kind_t frame_kind;
        logic  frame_last;
    } result_t;

endpackage

// ===== src/ipcfd_core.sv =====
module ipcfd_core
    import ipcfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  cfg_t       cfg,
    output result_t    result
);

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [TAG_BITS-1:0] len_reg, len_next;
    logic [POS_BITS-1:0] end_reg, end_next;
    kind_t               kind_reg, kind_next;
    logic                end_known_reg, end_known_next;
    logic                halt_reg, halt_next;
    logic [POS_BITS-1:0] n;
    logic [TAG_BITS-1:0] len_shifted;
    logic [POS_BITS-1:0] len_ext;
    logic                tag_miss;
    logic                too_big;

    always_comb
    begin
        n              = pos_reg + 34'd1;
        pos_next       = pos_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        end_next       = end_reg;
        kind_next      = kind_reg;
        end_known_next = end_known_reg;
        halt_next      = halt_reg;
        tag_miss       = 1'b0;
        result         = '0;
        if (halt_reg)
        begin
            result.halted = 1'b1;
        end
        else
        begin
            if (pos_reg < 34'd4)
            begin
                tag_next = {tag_reg[TAG_BITS-9:0], data_byte};
                if (pos_reg == 34'd3)
                begin
                    // first matching tag wins
                    priority if (tag_next == cfg.tag[CFG_TAG_HELLO])
                    begin
                        kind_next = KIND_HELLO;
                        end_next = END_HELLO;
                        end_known_next = 1'b1;
                    end
                    else if (tag_next == cfg.tag[CFG_TAG_READY])
                    begin
                        kind_next = KIND_READY;
                        end_next = END_READY;
                        end_known_next = 1'b1;
                    end
                    else if (tag_next == cfg.tag[CFG_TAG_ACTIVATED])
                    begin
                        kind_next = KIND_ACTIVATED;
                        end_next = END_ACTIVATED;
                        end_known_next = 1'b1;
                    end
                    else if (tag_next == cfg.tag[CFG_TAG_COMMAND])
                    begin
                        kind_next = KIND_COMMAND;
                        end_next = LEN_COMMAND;
                        end_known_next = 1'b0;
                    end
                    else if (tag_next == cfg.tag[CFG_TAG_STOP])
                    begin
                        kind_next = KIND_STOP;
                        end_next = END_STOP;
                        end_known_next = 1'b1;
                    end
                    else if (tag_next == cfg.tag[CFG_TAG_READY_V2])
                    begin
                        kind_next = KIND_READY_V2;
                        end_next = LEN_FIRST_V2;
                        end_known_next = 1'b0;
                    end
                    else
                    begin
                        tag_miss = 1'b1;
                    end
                end
            end
            else
            begin
                len_next = len_shifted;
            end

            if (tag_miss)
            begin
                halt_next = 1'b1;
                result.frame_invalid = 1'b1;
            end
            else
            begin
                pos_next = n;
                if (pos_reg >= 34'd3 && n == end_next)
                begin
                    if (end_known_next)
                    begin
                        result.frame_last = 1'b1;
                        result.frame_kind = kind_next;
                        pos_next = '0;
                        tag_next = '0;
                        len_next = '0;
                        end_next = '0;
                        kind_next = KIND_HELLO;
                        end_known_next = 1'b0;
                    end
                    else if (too_big)
                    begin
                        halt_next = 1'b1;
                        result.frame_invalid = 1'b1;
                    end
                    else if (kind_next == KIND_COMMAND)
                    begin
                        end_next = CMD_OVERHEAD + len_ext;
                        end_known_next = 1'b1;
                    end
                    else if (n == LEN_FIRST_V2)
                    begin
                        // second length sits right after the first string
                        end_next = V2_SECOND_BASE + len_ext;
                        end_known_next = 1'b0;
                    end
                    else
                    begin
                        end_next = n + len_ext + V2_TRAILER;
                        end_known_next = 1'b1;
                    end
                end
            end
        end
    end

    assign len_shifted = {len_reg[TAG_BITS-9:0], data_byte};
    assign len_ext = {{(POS_BITS-TAG_BITS){1'b0}}, len_shifted};
    assign too_big = ((len_shifted >> LENGTH_WIDTH) != '0) || (len_shifted > cfg.max_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            end_reg       <= '0;
            kind_reg      <= KIND_HELLO;
            end_known_reg <= 1'b0;
            halt_reg      <= 1'b0;
        end
        else if (step)
        begin
            pos_reg       <= pos_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            end_reg       <= end_next;
            kind_reg      <= kind_next;
            end_known_reg <= end_known_next;
            halt_reg      <= halt_next;
        end
    end

endmodule

// ===== src/ipc_frame_delimiter.sv =====
// ipc frame delimiter
// input stream (s_*): one received byte per transfer in s_tdata[7:0]
// output stream (m_*): one result per input byte, in order
//   m_tlast marks the last byte of a frame, m_tdata[2:0] gives the frame kind
//   (0 hello, 1 ready, 2 activated, 3 command, 4 stop, 5 ready v2) when m_tlast is set
//   m_tuser[0] flags the byte that exposes an unknown tag or an oversize length
//   m_tuser[1] flags a byte dropped because the stream is halted
// config port: cfg_wr_en writes cfg_data into register cfg_index
//   0..5 tags (hello, ready, activated, command, stop, ready v2), 6 max length
//   write only while the stream is idle
// throughput: one byte per cycle while the receiver takes results; the byte register and the
//   result register form a two-stage pipeline, with the combinational tag compare and end add between them
// a stalled receiver holds the result; at most one more byte is taken, then s_tready drops
// reset clears the frame state and the halt flag, tags to 0, max length to 4096
// after an invalid frame every byte is dropped and flagged until reset
module ipc_frame_delimiter
    import ipcfd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // data_byte
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,   // frame_kind, zero fill
    output logic [1:0]              m_tuser,   // frame_invalid, halted
    output logic                    m_tlast,   // frame_last
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [TAG_BITS-1:0]     cfg_data
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    result;
    cfg_t       cfg_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tag        <= '0;
            cfg_reg.max_length <= MAX_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TAG_HELLO:     cfg_reg.tag[CFG_TAG_HELLO]     <= cfg_data;
                CFG_TAG_READY:     cfg_reg.tag[CFG_TAG_READY]     <= cfg_data;
                CFG_TAG_ACTIVATED: cfg_reg.tag[CFG_TAG_ACTIVATED] <= cfg_data;
                CFG_TAG_COMMAND:   cfg_reg.tag[CFG_TAG_COMMAND]   <= cfg_data;
                CFG_TAG_STOP:      cfg_reg.tag[CFG_TAG_STOP]      <= cfg_data;
                CFG_TAG_READY_V2:  cfg_reg.tag[CFG_TAG_READY_V2]  <= cfg_data;
                CFG_MAX_LENGTH:    cfg_reg.max_length             <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    ipcfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .result    (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_result_reg.frame_kind};
    assign m_tuser  = {out_result_reg.halted, out_result_reg.frame_invalid};
    assign m_tlast  = out_result_reg.frame_last;

endmodule

// ===== src/ipcfd_checker.sv =====
module ipcfd_checker
    import ipcfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    input  logic       m_tlast
);

    // stalled transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output changed while stalled");

    // at most one of frame end, invalid, halted
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({m_tlast, m_tuser}))
        else $error("conflicting result flags");

    // kind only with frame end, and a known kind
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast || m_tdata == 8'd0) && m_tdata[2:0] != 3'd6
            && m_tdata[2:0] != 3'd7 && m_tdata[7:3] == 5'd0)
        else $error("bad frame kind");

    // once an invalid or halted result is taken, m_tvalid drops or the result after it is halted
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser[0] || m_tuser[1]) |=> !m_tvalid || m_tuser[1])
        else $error("stream resumed after invalid frame");

endmodule

bind ipc_frame_delimiter ipcfd_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import ipcfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int PRINT_CAP = 100;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 3'd7;

    typedef enum logic {ROW_DATA, ROW_WRITE} row_op_t;
    typedef enum int {FAULT_NONE, FAULT_FIRST_LENGTH, FAULT_SECOND_LENGTH} fault_t;
    typedef enum int {BREAK_TAG, BREAK_COMMAND, BREAK_V2_FIRST, BREAK_V2_SECOND} break_t;

    typedef struct {
        row_op_t                 op;
        logic [CFG_IDX_BITS-1:0] index;
        logic [TAG_BITS-1:0]     value;
        bit                      typed;
        result_t                 want;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [7:0]              m_tdata;   // frame_kind, zero fill
    logic [1:0]              m_tuser;   // frame_invalid, halted
    logic                    m_tlast;   // frame_last
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [TAG_BITS-1:0]     cfg_data = '0;

    ipc_frame_delimiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // delimiter state as the testbench sees it
    logic [TAG_BITS-1:0] tag_cfg [NUM_TAGS] = '{default: '0};
    logic [TAG_BITS-1:0] max_len = MAX_LENGTH_RESET;
    logic [POS_BITS-1:0] pos_count = '0;
    logic [POS_BITS-1:0] end_count = '0;
    logic [31:0]         tag_acc = '0;
    logic [31:0]         len_acc = '0;
    kind_t               cur_kind = KIND_HELLO;
    logic                end_known = 1'b0;
    logic                stream_halted = 1'b0;

    result_t    byte_verdicts [$];
    stim_row_t  script [$];
    logic [7:0] frame_bytes [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int bytes_sent = 0;
    int invalid_seen = 0;
    int halted_seen = 0;
    int frames_per_kind [NUM_TAGS] = '{default: 0};

    function automatic result_t delimit_byte(input logic [7:0] b);
        result_t r;
        logic [POS_BITS-1:0] nxt;
        r = '0;
        nxt = pos_count + 1'b1;
        if (stream_halted) begin
            r.halted = 1'b1;
            return r;
        end
        if (pos_count < 4) begin
            tag_acc = {tag_acc[23:0], b};
            if (pos_count == 3) begin
                // earliest matching tag wins
                if (tag_acc == tag_cfg[CFG_TAG_HELLO]) begin
                    cur_kind = KIND_HELLO; end_count = END_HELLO; end_known = 1'b1;
                end else if (tag_acc == tag_cfg[CFG_TAG_READY]) begin
                    cur_kind = KIND_READY; end_count = END_READY; end_known = 1'b1;
                end else if (tag_acc == tag_cfg[CFG_TAG_ACTIVATED]) begin
                    cur_kind = KIND_ACTIVATED; end_count = END_ACTIVATED; end_known = 1'b1;
                end else if (tag_acc == tag_cfg[CFG_TAG_COMMAND]) begin
                    cur_kind = KIND_COMMAND; end_count = LEN_COMMAND; end_known = 1'b0;
                end else if (tag_acc == tag_cfg[CFG_TAG_STOP]) begin
                    cur_kind = KIND_STOP; end_count = END_STOP; end_known = 1'b1;
                end else if (tag_acc == tag_cfg[CFG_TAG_READY_V2]) begin
                    cur_kind = KIND_READY_V2; end_count = LEN_FIRST_V2; end_known = 1'b0;
                end else begin
                    stream_halted = 1'b1;
                    r.frame_invalid = 1'b1;
                    return r;
                end
            end
        end else begin
            len_acc = {len_acc[23:0], b};
        end
        if (pos_count >= 3 && nxt == end_count) begin
            if (end_known) begin
                r.frame_last = 1'b1;
                r.frame_kind = cur_kind;
                pos_count = '0;
                end_count = '0;
                tag_acc = '0;
                len_acc = '0;
                cur_kind = KIND_HELLO;
                end_known = 1'b0;
                return r;
            end
            if (((len_acc >> LENGTH_WIDTH) != 0) || (len_acc > max_len)) begin
                stream_halted = 1'b1;
                r.frame_invalid = 1'b1;
                return r;
            end
            if (cur_kind == KIND_COMMAND) begin
                end_count = CMD_OVERHEAD + {2'b00, len_acc};
                end_known = 1'b1;
            end else if (nxt == LEN_FIRST_V2) begin
                // second length sits in the four bytes after the first string
                end_count = V2_SECOND_BASE + {2'b00, len_acc};
                end_known = 1'b0;
            end else begin
                end_count = nxt + {2'b00, len_acc} + V2_TRAILER;
                end_known = 1'b1;
            end
        end
        pos_count = nxt;
        return r;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        script.push_back('{ROW_DATA, '0, {24'h0, b}, 1'b0, '0});
    endfunction

    function automatic void add_frame_end(input logic [7:0] b, input kind_t k);
        result_t w;
        w = '0;
        w.frame_last = 1'b1;
        w.frame_kind = k;
        script.push_back('{ROW_DATA, '0, {24'h0, b}, 1'b1, w});
    endfunction

    function automatic void add_write(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [TAG_BITS-1:0] value);
        script.push_back('{ROW_WRITE, idx, value, 1'b0, '0});
    endfunction

    function automatic void push_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void push_random(input int n);
        for (int i = 0; i < n; i++)
            frame_bytes.push_back(8'($urandom));
    endfunction

    function automatic logic [31:0] pick_length();
        logic [31:0] cap;
        cap = (max_len < 32'd40) ? max_len : 32'd40;
        if ($urandom_range(3) == 0)
            return cap;
        if (max_len > 32'd200 && $urandom_range(19) == 0)
            return 32'($urandom_range(200, 41));
        return 32'($urandom_range(cap, 0));
    endfunction

    function automatic logic [31:0] oversize_length();
        if ($urandom_range(2) == 0)
            return '1;
        return max_len + 32'd1 + 32'($urandom_range(1000));
    endfunction

    // builds one frame for the kind that the tag in this slot decodes to
    function automatic void queue_frame(input int slot, input fault_t fault);
        kind_t k;
        logic [31:0] len_a;
        logic [31:0] len_b;
        k = KIND_HELLO;
        for (int j = NUM_TAGS - 1; j >= 0; j--)
            if (tag_cfg[j] == tag_cfg[slot])
                k = kind_t'(j);
        push_word(tag_cfg[slot]);
        case (k)
            KIND_HELLO:     push_random(int'(END_HELLO) - 4);
            KIND_READY:     ;
            KIND_ACTIVATED: push_random(int'(END_ACTIVATED) - 4);
            KIND_STOP:      push_random(int'(END_STOP) - 4);
            KIND_COMMAND:
            begin
                len_a = (fault == FAULT_FIRST_LENGTH) ? oversize_length() : pick_length();
                push_word(len_a);
                if (fault == FAULT_NONE)
                    push_random(int'(len_a) + int'(CMD_OVERHEAD - LEN_COMMAND));
            end
            default:
            begin
                push_random(int'(LEN_FIRST_V2) - 8);
                len_a = (fault == FAULT_FIRST_LENGTH) ? oversize_length() : pick_length();
                push_word(len_a);
                if (fault != FAULT_FIRST_LENGTH)
                begin
                    push_random(int'(len_a));
                    len_b = (fault == FAULT_SECOND_LENGTH) ? oversize_length() : pick_length();
                    push_word(len_b);
                    if (fault == FAULT_NONE)
                        push_random(int'(len_b) + int'(V2_TRAILER));
                end
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string note);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch on result %0d: %s", results_checked, note);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = delimit_byte(b);
        byte_verdicts.push_back(typed ? want : r);
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (frame_bytes.size() != 0)
            send_byte(frame_bytes.pop_front(), 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (byte_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [TAG_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx < NUM_TAGS)
            tag_cfg[idx] = value;
        else if (idx == CFG_MAX_LENGTH)
            max_len = value;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_fresh_tags();
        logic [TAG_BITS-1:0] picks [NUM_TAGS];
        bit clash;
        for (int i = 0; i < NUM_TAGS; i++)
        begin
            do
            begin
                picks[i] = $urandom;
                clash = 1'b0;
                for (int j = 0; j < i; j++)
                    if (picks[j] == picks[i])
                        clash = 1'b1;
            end while (clash);
            write_reg(CFG_IDX_BITS'(i), picks[i]);
        end
    endtask

    task automatic run_frames(input int target);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            queue_frame($urandom_range(NUM_TAGS - 1), FAULT_NONE);
            sent += frame_bytes.size();
            send_queued();
        end
    endtask

    // one broken frame halts the stream for the rest of the run
    task automatic break_stream();
        break_t how;
        logic [TAG_BITS-1:0] bogus;
        bit clash;
        how = break_t'($urandom_range(3));
        case (how)
            BREAK_TAG:
            begin
                do
                begin
                    bogus = $urandom;
                    clash = 1'b0;
                    for (int i = 0; i < NUM_TAGS; i++)
                        if (tag_cfg[i] == bogus)
                            clash = 1'b1;
                end while (clash);
                push_word(bogus);
            end
            BREAK_COMMAND:  queue_frame(CFG_TAG_COMMAND, FAULT_FIRST_LENGTH);
            BREAK_V2_FIRST: queue_frame(CFG_TAG_READY_V2, FAULT_FIRST_LENGTH);
            default:        queue_frame(CFG_TAG_READY_V2, FAULT_SECOND_LENGTH);
        endcase
        push_random(60);
        send_queued();
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin : rx_side
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (byte_verdicts.size() == 0)
                    flag_mismatch("result with nothing outstanding");
                else
                begin
                    want = byte_verdicts.pop_front();
                    if (m_tlast !== want.frame_last)
                        flag_mismatch($sformatf("frame_last got %b want %b",
                                                m_tlast, want.frame_last));
                    if (m_tdata[2:0] !== want.frame_kind)
                        flag_mismatch($sformatf("frame_kind got %0d want %0d",
                                                m_tdata[2:0], want.frame_kind));
                    if (m_tuser[0] !== want.frame_invalid)
                        flag_mismatch($sformatf("frame_invalid got %b want %b",
                                                m_tuser[0], want.frame_invalid));
                    if (m_tuser[1] !== want.halted)
                        flag_mismatch($sformatf("halted got %b want %b",
                                                m_tuser[1], want.halted));
                    if (want.frame_last)
                        frames_per_kind[want.frame_kind]++;
                    if (want.frame_invalid)
                        invalid_seen++;
                    if (want.halted)
                        halted_seen++;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        // tags are all zero after reset, so a zero tag decodes as hello
        for (int i = 0; i < 4; i++)
            add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h80);
        add_byte(8'h7F);
        add_frame_end(8'h01, KIND_HELLO);
        add_write(CFG_TAG_HELLO, 32'h0000_0000);
        add_write(CFG_TAG_READY, 32'hFFFF_FFFF);
        add_write(CFG_TAG_ACTIVATED, 32'hA5C3_0F81);
        add_write(CFG_TAG_COMMAND, 32'h434D_4430);
        add_write(CFG_TAG_STOP, 32'h5354_4F50);
        add_write(CFG_TAG_READY_V2, 32'h5256_3200);
        add_write(CFG_UNMAPPED, 32'h0000_0BAD);
        for (int i = 0; i < 3; i++)
            add_byte(8'hFF);
        add_frame_end(8'hFF, KIND_READY);
        // command with zero length
        add_byte(8'h43);
        add_byte(8'h4D);
        add_byte(8'h44);
        add_byte(8'h30);
        for (int i = 0; i < 4; i++)
            add_byte(8'h00);
        add_frame_end(8'hAA, KIND_COMMAND);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].op == ROW_WRITE)
            begin
                wait_drained();
                write_reg(script[i].index, script[i].value);
            end
            else
                send_byte(script[i].value[7:0], script[i].typed, script[i].want);
        end
        run_frames(300);

        wait_drained();
        program_fresh_tags();
        write_reg(CFG_MAX_LENGTH, 32'd20);
        send_idle_pct = 45;
        run_frames(300);

        // shadowed tags, zero length limit
        wait_drained();
        program_fresh_tags();
        write_reg(CFG_TAG_STOP, tag_cfg[CFG_TAG_HELLO]);
        write_reg(CFG_TAG_READY_V2, tag_cfg[CFG_TAG_ACTIVATED]);
        write_reg(CFG_MAX_LENGTH, '0);
        send_idle_pct = 0;
        recv_stall_pct = 45;
        run_frames(250);

        // widest length limit, long receiver hold-off at the start
        wait_drained();
        program_fresh_tags();
        write_reg(CFG_MAX_LENGTH, '1);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        hold_requests++;
        run_frames(250);

        wait_drained();
        program_fresh_tags();
        write_reg(CFG_MAX_LENGTH, 32'($urandom_range(64, 8)));
        run_frames(100);
        break_stream();

        wait_drained();
        $display("run covered %0d bytes; frames hello %0d ready %0d activated %0d",
                 bytes_sent, frames_per_kind[KIND_HELLO], frames_per_kind[KIND_READY],
                 frames_per_kind[KIND_ACTIVATED]);
        $display("command %0d stop %0d ready_v2 %0d; invalid %0d, halted bytes %0d",
                 frames_per_kind[KIND_COMMAND], frames_per_kind[KIND_STOP],
                 frames_per_kind[KIND_READY_V2], invalid_seen, halted_seen);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/ipcfd_pkg.sv
src/ipcfd_core.sv
src/ipc_frame_delimiter.sv
src/ipcfd_checker.sv
test/tb.sv
